/* design/rtpt_pkg.sv */
// ----------------------------------------------------------------------------
// rtpt_pkg: shared types and constants for the range toggle / point parity tree
// Field widths, function codes, the item and result beats, reset values.
// ----------------------------------------------------------------------------
package rtpt_pkg;

	localparam int LEAF_BITS_DEF = 10;
	localparam int IDX_W         = 11;
	localparam int SIZE_W        = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

	localparam logic FUNC_TOGGLE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] last_index;
	} item_t;

	typedef struct packed {
		logic parity;
		logic index_error;
	} res_t;

endpackage

/* design/rtpt_ram.sv */
// ----------------------------------------------------------------------------
// rtpt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rtpt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/rtpt_seq.sv */
// ----------------------------------------------------------------------------
// rtpt_seq: tree walk sequencer
// Clears the mark store after reset, then runs one item at a time: a toggle
// climbs from both range ends flipping covering nodes through one shared
// read-modify-write port; a query XORs marks on the leaf-to-root path.
// ----------------------------------------------------------------------------
module rtpt_seq #(
	parameter int LEAF_BITS = rtpt_pkg::LEAF_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rtpt_pkg::SIZE_W-1:0] k,
	input  logic                        item_take,
	input  rtpt_pkg::item_t             item,
	output logic                        ready,
	output logic                        res_valid,
	input  logic                        res_take,
	output rtpt_pkg::res_t              res
);
	import rtpt_pkg::*;

	localparam int NW    = LEAF_BITS + 1;
	localparam int DEPTH = 2 ** NW;
	localparam int WW    = NW + IDX_W;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LO    = 7'b0000100,
		S_HI    = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_QRY   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   clr_q;
	logic [NW-1:0]   lo_q;
	logic [NW-1:0]   hi_q;
	logic [NW-1:0]   wr_addr_q;
	logic            wr_pend_q;
	logic            rd_pend_q;
	logic            acc_q;
	logic            err_q;

	logic            we;
	logic [NW-1:0]   waddr;
	logic            wdata;
	logic [NW-1:0]   raddr;
	logic            rdata;

	logic            ok_first;
	logic            ok_last;
	logic [WW-1:0]   first_w;
	logic [WW-1:0]   last_w;
	logic [NW-1:0]   first_node;
	logic [NW-1:0]   last_node;

	// index is valid when 1 <= idx <= 2^k, i.e. (idx - 1) < 2^k
	assign ok_first = (item.first_index != '0) &&
		(((item.first_index - IDX_W'(1)) >> k) == '0);
	assign ok_last  = (item.last_index != '0) &&
		(((item.last_index - IDX_W'(1)) >> k) == '0);

	// leaf node = 2^k - 1 + idx
	assign first_w    = WW'(item.first_index) + (WW'(1) << k) - WW'(1);
	assign last_w     = WW'(item.last_index) + (WW'(1) << k) - WW'(1);
	assign first_node = first_w[NW-1:0];
	assign last_node  = last_w[NW-1:0];

	always_comb begin
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 1'b0;
		end else begin
			we    = wr_pend_q;
			waddr = wr_addr_q;
			wdata = ~rdata;
		end
	end

	always_comb begin
		case (state_q)
			S_HI:    raddr = hi_q;
			default: raddr = lo_q;
		endcase
	end

	rtpt_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_marks (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			wr_addr_q <= '0;
			wr_pend_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_take) begin
						lo_q <= first_node;
						hi_q <= last_node;
						if (item.func == FUNC_TOGGLE) begin
							if (!(ok_first && ok_last) ||
							    (item.first_index > item.last_index)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_LO;
							end
						end else begin
							rd_pend_q <= 1'b0;
							state_q   <= ok_first ? S_QRY : S_DONE;
						end
					end
				end
				S_LO: begin
					if (lo_q < hi_q) begin
						if (lo_q[0]) begin
							wr_pend_q <= 1'b1;
							wr_addr_q <= lo_q;
							lo_q      <= (lo_q >> 1) + NW'(1);
						end else begin
							lo_q <= lo_q >> 1;
						end
						state_q <= S_HI;
					end else begin
						if (lo_q == hi_q) begin
							wr_pend_q <= 1'b1;
							wr_addr_q <= lo_q;
						end
						state_q <= S_FIN;
					end
				end
				S_HI: begin
					if (!hi_q[0]) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= hi_q;
						hi_q      <= (hi_q >> 1) - NW'(1);
					end else begin
						hi_q <= hi_q >> 1;
					end
					state_q <= S_LO;
				end
				S_FIN: begin
					// last pending flip lands this cycle
					state_q <= S_DONE;
				end
				S_QRY: begin
					if (lo_q != '0) begin
						rd_pend_q <= 1'b1;
						lo_q      <= lo_q >> 1;
					end else begin
						rd_pend_q <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_take) begin
			acc_q <= 1'b0;
			if (item.func == FUNC_TOGGLE) begin
				err_q <= !(ok_first && ok_last);
			end else begin
				err_q <= !ok_first;
			end
		end else if (state_q == S_QRY && rd_pend_q) begin
			acc_q <= acc_q ^ rdata;
		end
	end

	assign ready           = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.parity      = acc_q;
	assign res.index_error = err_q;

endmodule

/* design/range_toggle_point_parity_tree_unit.sv */
// ----------------------------------------------------------------------------
// range_toggle_point_parity_tree_unit: range toggle / point parity tree
// Input channel carries func, first_index, last_index; each item gives one
// result beat on the output channel with parity and index_error.
// A toggle flips positions first_index..last_index; a query returns the
// parity of position first_index. Invalid indices set index_error and the
// item changes nothing. size_log2 is written on the cfg channel (always
// ready) and must only change while the block is idle.
// A toggle walks the tree level by level, one mark-RAM read-modify-write per
// covering node, reads overlapped with the previous write; a query does one
// RAM read per level; rejected items skip the walk. k, the effective
// size_log2, sets the tree depth.
// One item at a time: in_stall is high from acceptance until the result
// enters the output register. The output register frees the sequencer, so
// the next item is taken while a result still waits under out_stall.
// Reset: marks are cleared by a pass over all 2^(LEAF_BITS+1) mark addresses
// (2048 by default) with in_stall high; size_log2 resets to 10.
// ----------------------------------------------------------------------------
module range_toggle_point_parity_tree_unit #(
	parameter int LEAF_BITS = rtpt_pkg::LEAF_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [rtpt_pkg::IDX_W-1:0]  first_index,
	input  logic [rtpt_pkg::IDX_W-1:0]  last_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        parity,
	output logic                        index_error,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rtpt_pkg::SIZE_W-1:0] cfg_data
);
	import rtpt_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] k;
	logic              seq_ready;
	logic              item_take;
	item_t             item;
	logic              res_valid;
	logic              res_take;
	res_t              res;
	logic              out_vld_q;
	res_t              out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// sizes beyond the tree saturate
	assign k = (int'(size_q) > LEAF_BITS) ? SIZE_W'(LEAF_BITS) : size_q;

	assign item.func        = func;
	assign item.first_index = first_index;
	assign item.last_index  = last_index;
	assign in_stall         = !seq_ready;
	assign item_take        = in_valid && seq_ready;

	rtpt_seq #(
		.LEAF_BITS (LEAF_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.k         (k),
		.item_take (item_take),
		.item      (item),
		.ready     (seq_ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = res_valid && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_vld_q;
	assign parity      = out_q.parity;
	assign index_error = out_q.index_error;

endmodule

/* design/rtpt_checker.sv */
// ----------------------------------------------------------------------------
// rtpt_checker: port-level checks for the range toggle / point parity tree
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module rtpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic parity,
	input logic index_error
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parity) && $stable(index_error))
		else $error("result beat changed under stall");

	// a rejected item never reports parity
	a_err_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> !parity)
		else $error("parity set on rejected item");

	// one item at a time: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// a new result only comes out of a busy cycle
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a pending item");

endmodule

bind range_toggle_point_parity_tree_unit rtpt_checker u_rtpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.parity      (parity),
	.index_error (index_error)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: range toggle / point parity tree unit
// Sends toggle and query beats under several size settings and stall mixes.
// A behavioral copy of the mark tree predicts each result beat, and every
// beat taken from the output channel is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LEAVES_MAX = 1 << rtpt_pkg::LEAF_BITS_DEF;
	localparam int NODES      = 2 << rtpt_pkg::LEAF_BITS_DEF;
	localparam int IDX_MAX    = (1 << rtpt_pkg::IDX_W) - 1;
	localparam int IDX_W      = rtpt_pkg::IDX_W;
	localparam int SIZE_W     = rtpt_pkg::SIZE_W;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        func;
	logic [rtpt_pkg::IDX_W-1:0]  first_index;
	logic [rtpt_pkg::IDX_W-1:0]  last_index;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        parity;
	logic                        index_error;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [rtpt_pkg::SIZE_W-1:0] cfg_data;

	// predictor state
	bit                          tree_marks [NODES];
	logic [rtpt_pkg::SIZE_W-1:0] size_reg;
	rtpt_pkg::res_t              result_q [$];
	int                          fail_count = 0;
	int                          sender_idle_pct = 0;
	int                          receiver_stall_pct = 0;

	range_toggle_point_parity_tree_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.first_index (first_index),
		.last_index  (last_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.parity      (parity),
		.index_error (index_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned leaf_count();
		int unsigned k;
		k = (size_reg > rtpt_pkg::LEAF_BITS_DEF) ? rtpt_pkg::LEAF_BITS_DEF : size_reg;
		return 1 << k;
	endfunction

	function automatic void flip_node(int unsigned node);
		tree_marks[node & (NODES - 1)] ^= 1'b1;
	endfunction

	// bottom-up walk from both ends, flipping only the covering nodes
	function automatic void toggle_span(int unsigned lo, int unsigned hi);
		while (lo < hi) begin
			if (lo[0]) begin
				flip_node(lo);
				lo = (lo >> 1) + 1;
			end else begin
				lo = lo >> 1;
			end
			if (hi[0]) begin
				hi = hi >> 1;
			end else begin
				flip_node(hi);
				hi = (hi >> 1) - 1;
			end
		end
		if (lo == hi)
			flip_node(lo);
	endfunction

	function automatic bit path_xor(int unsigned node);
		bit acc;
		acc = 1'b0;
		while (node != 0) begin
			acc ^= tree_marks[node & (NODES - 1)];
			node = node >> 1;
		end
		return acc;
	endfunction

	function automatic rtpt_pkg::res_t predict_parity(rtpt_pkg::item_t it);
		int unsigned    leaves;
		int unsigned    base;
		bit             first_ok;
		bit             last_ok;
		rtpt_pkg::res_t r;
		leaves   = leaf_count();
		base     = leaves - 1;
		first_ok = (it.first_index >= 1) && (it.first_index <= leaves);
		last_ok  = (it.last_index >= 1) && (it.last_index <= leaves);
		r        = '0;
		if (it.func == rtpt_pkg::FUNC_TOGGLE) begin
			if (!first_ok || !last_ok)
				r.index_error = 1'b1;
			else if (it.first_index <= it.last_index)
				toggle_span(base + it.first_index, base + it.last_index);
		end else begin
			if (!first_ok)
				r.index_error = 1'b1;
			else
				r.parity = path_xor(base + it.first_index);
		end
		return r;
	endfunction

	task automatic send_item(input logic f, input int unsigned a, input int unsigned b);
		rtpt_pkg::item_t it;
		it.func        = f;
		it.first_index = IDX_W'(a);
		it.last_index  = IDX_W'(b);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		func        = it.func;
		first_index = it.first_index;
		last_index  = it.last_index;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		result_q.push_back(predict_parity(it));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_size(input int unsigned v);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = SIZE_W'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		size_reg = SIZE_W'(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int unsigned stray_index(int unsigned leaves);
		case ($urandom_range(2))
			0: return 0;
			1: return $urandom_range(IDX_MAX, leaves + 1);
			default: return $urandom_range(IDX_MAX, 0);
		endcase
	endfunction

	task automatic send_random_item();
		int unsigned leaves;
		int unsigned a;
		int unsigned b;
		int unsigned t;
		logic        f;
		leaves = leaf_count();
		f      = 1'($urandom_range(1));
		if ($urandom_range(99) < 82) begin
			a = $urandom_range(leaves, 1);
			b = $urandom_range(leaves, 1);
			// mostly ordered ranges, some reversed ones left as is
			if (a > b && $urandom_range(99) < 85) begin
				t = a;
				a = b;
				b = t;
			end
			if (f == rtpt_pkg::FUNC_QUERY)
				b = $urandom_range(IDX_MAX, 0);
		end else begin
			a = stray_index(leaves);
			b = $urandom_range(1) ? stray_index(leaves) : $urandom_range(leaves, 1);
			if ($urandom_range(1)) begin
				t = a;
				a = b;
				b = t;
			end
		end
		send_item(f, a, b);
	endtask

	task automatic test_full_size_directed();
		send_item(rtpt_pkg::FUNC_TOGGLE, 1, LEAVES_MAX);
		send_item(rtpt_pkg::FUNC_QUERY, 1, 0);
		send_item(rtpt_pkg::FUNC_QUERY, LEAVES_MAX, 0);
		send_item(rtpt_pkg::FUNC_TOGGLE, 3, 700);
		send_item(rtpt_pkg::FUNC_QUERY, 2, 0);
		send_item(rtpt_pkg::FUNC_QUERY, 3, 0);
		send_item(rtpt_pkg::FUNC_QUERY, 700, 0);
		send_item(rtpt_pkg::FUNC_QUERY, 701, IDX_MAX);
		// reversed range: no change, no error
		send_item(rtpt_pkg::FUNC_TOGGLE, 10, 5);
		send_item(rtpt_pkg::FUNC_QUERY, 7, 0);
		send_item(rtpt_pkg::FUNC_TOGGLE, 0, 5);
		send_item(rtpt_pkg::FUNC_TOGGLE, 5, LEAVES_MAX + 1);
		send_item(rtpt_pkg::FUNC_TOGGLE, IDX_MAX, IDX_MAX);
		send_item(rtpt_pkg::FUNC_QUERY, 0, 1);
		send_item(rtpt_pkg::FUNC_QUERY, LEAVES_MAX + 1, 1);
		send_item(rtpt_pkg::FUNC_QUERY, IDX_MAX, IDX_MAX);
		send_item(rtpt_pkg::FUNC_TOGGLE, LEAVES_MAX, LEAVES_MAX);
		send_item(rtpt_pkg::FUNC_QUERY, LEAVES_MAX, 0);
		send_item(rtpt_pkg::FUNC_TOGGLE, 1, 1);
		send_item(rtpt_pkg::FUNC_QUERY, 1, 0);
	endtask

	// marks survive size changes and are read under the new layout
	task automatic test_size_extremes();
		write_size(0);
		send_item(rtpt_pkg::FUNC_TOGGLE, 1, 1);
		send_item(rtpt_pkg::FUNC_QUERY, 1, 0);
		send_item(rtpt_pkg::FUNC_QUERY, 2, 0);
		send_item(rtpt_pkg::FUNC_TOGGLE, 1, 2);
		write_size(15);
		send_item(rtpt_pkg::FUNC_QUERY, 1, 0);
		send_item(rtpt_pkg::FUNC_QUERY, LEAVES_MAX, 0);
		send_item(rtpt_pkg::FUNC_TOGGLE, LEAVES_MAX + 1, 1);
		write_size(1);
		send_item(rtpt_pkg::FUNC_TOGGLE, 2, 1);
		send_item(rtpt_pkg::FUNC_QUERY, 2, 0);
	endtask

	task automatic test_random_traffic();
		int sizes [16] = '{1, 4, 10, 15, 0, 6, 11, 3, 8, 2, 13, 9, 5, 7, 12, 14};
		int idle_mix [4] = '{0, 59, 0, 34};
		int stall_mix [4] = '{0, 0, 59, 34};
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct    = idle_mix[ph];
			receiver_stall_pct = stall_mix[ph];
			for (int s = 0; s < 4; s++) begin
				write_size(sizes[ph * 4 + s]);
				repeat (116) send_random_item();
			end
		end
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin
		rtpt_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result beat with no expectation pending");
				fail_count++;
			end else begin
				want = result_q.pop_front();
				if (parity !== want.parity) begin
					$error("parity mismatch: expected %0b, actual %0b", want.parity, parity);
					fail_count++;
				end
				if (index_error !== want.index_error) begin
					$error("index_error mismatch: expected %0b, actual %0b",
						want.index_error, index_error);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = rtpt_pkg::FUNC_TOGGLE;
		first_index = '0;
		last_index  = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		size_reg    = rtpt_pkg::SIZE_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_full_size_directed();
		test_size_extremes();
		test_random_traffic();

		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && result_q.size() == 0)
			$display("range_toggle_point_parity_tree_unit test passed");
		else
			$display("range_toggle_point_parity_tree_unit test failed");
		$finish;
	end

	// generous watchdog bound on the whole run
	initial begin
		#12000000;
		$display("range_toggle_point_parity_tree_unit test failed");
		$finish;
	end

endmodule
